[design/pfi_pkg.sv]
// Package for the palette fade interpolator: shared constants, types and helpers.
// Used by every module of the block and by its checker. No dependencies.
package pfi_pkg;

  localparam int unsigned NumChan = 3;
  localparam int unsigned QBits   = 16;
  // front stage + one divider cell per quotient bit + back stage
  localparam int unsigned Latency = QBits + 2;

  typedef enum logic [2:0] {
    REG_FADE_MODE    = 3'd0,
    REG_TARGET_RED   = 3'd1,
    REG_TARGET_GREEN = 3'd2,
    REG_TARGET_BLUE  = 3'd3,
    REG_STEP_COUNT   = 3'd4,
    REG_RANGE_START  = 3'd5,
    REG_RANGE_END    = 3'd6
  } pfi_reg_e;

  typedef struct packed {
    logic       mode;
    logic [5:0] tgt_red;
    logic [5:0] tgt_green;
    logic [5:0] tgt_blue;
    logic [7:0] steps;
    logic [7:0] rng_start;
    logic [7:0] rng_end;
  } pfi_cfg_t;

  // One color channel on its way through the divider chain.
  typedef struct packed {
    logic [15:0] dvd;   // dividend bits still to consume, quotient bits shifted in
    logic [7:0]  rem;   // partial remainder
    logic        neg;   // target below original
    logic [7:0]  orig;  // original 8-bit channel
  } pfi_lane_t;

  typedef struct packed {
    pfi_lane_t [NumChan-1:0] lane;  // 2 red, 1 green, 0 blue
    logic                    pass;  // entry outside range, send cur unchanged
    logic                    alpha;
    logic [15:0]             cur;
  } pfi_item_t;

  // v * 255 / 63 == 4v + v / 21 for v in 0..63
  function automatic logic [7:0] vga_widen(logic [5:0] v);
    logic [1:0] frac;
    frac = 2'(v >= 6'd21) + 2'(v >= 6'd42) + 2'(v >= 6'd63);
    return {v, 2'b00} + {6'd0, frac};
  endfunction

endpackage

[design/pfi_front.sv]
// Front stage: unpacks channels, picks targets, forms |delta| * step per channel.
// Depends on pfi_pkg.
module pfi_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        entry_index_i,
  input  logic [7:0]        step_index_i,
  input  logic [15:0]       current_color_i,
  input  logic [15:0]       target_color_i,
  input  pfi_pkg::pfi_cfg_t cfg_i,
  output pfi_pkg::pfi_item_t item_o,
  output logic              valid_o
);
  import pfi_pkg::*;

  logic [7:0] orig [NumChan];
  logic [7:0] tgt  [NumChan];
  pfi_item_t  item_d, item_q;
  logic       valid_q;

  always_comb begin
    logic [7:0] mag;
    orig[2] = {current_color_i[15:11], 3'b000};
    orig[1] = {current_color_i[10:6], 3'b000};
    orig[0] = {current_color_i[5:1], 3'b000};
    if (cfg_i.mode) begin
      tgt[2] = {target_color_i[15:11], 3'b000};
      tgt[1] = {target_color_i[10:6], 3'b000};
      tgt[0] = {target_color_i[5:1], 3'b000};
    end else begin
      tgt[2] = vga_widen(cfg_i.tgt_red);
      tgt[1] = vga_widen(cfg_i.tgt_green);
      tgt[0] = vga_widen(cfg_i.tgt_blue);
    end
    item_d.pass  = (entry_index_i < cfg_i.rng_start) || (entry_index_i > cfg_i.rng_end);
    item_d.alpha = cfg_i.mode ? 1'b1 : current_color_i[0];
    item_d.cur   = current_color_i;
    for (int c = 0; c < NumChan; c++) begin
      item_d.lane[c].neg  = tgt[c] < orig[c];
      mag                 = item_d.lane[c].neg ? (orig[c] - tgt[c]) : (tgt[c] - orig[c]);
      item_d.lane[c].dvd  = 16'(mag) * 16'(step_index_i);
      item_d.lane[c].rem  = '0;
      item_d.lane[c].orig = orig[c];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      item_q <= item_d;
    end
  end

  assign item_o  = item_q;
  assign valid_o = valid_q;

endmodule

[design/pfi_cell.sv]
// Divider cell: one restoring quotient bit for every channel, registered.
// Depends on pfi_pkg.
module pfi_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         divisor_i,
  input  pfi_pkg::pfi_item_t item_i,
  input  logic               valid_i,
  output pfi_pkg::pfi_item_t item_o,
  output logic               valid_o
);
  import pfi_pkg::*;

  pfi_item_t item_d, item_q;
  logic      valid_q;

  always_comb begin
    logic [8:0] rem_n;
    logic       ge;
    item_d = item_i;
    for (int c = 0; c < NumChan; c++) begin
      rem_n = {item_i.lane[c].rem, item_i.lane[c].dvd[15]};
      ge    = rem_n >= {1'b0, divisor_i};
      if (ge) begin
        rem_n = rem_n - {1'b0, divisor_i};
      end
      item_d.lane[c].rem = rem_n[7:0];
      item_d.lane[c].dvd = {item_i.lane[c].dvd[14:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      item_q <= item_d;
    end
  end

  assign item_o  = item_q;
  assign valid_o = valid_q;

endmodule

[design/pfi_back.sv]
// Back stage: applies signed quotient, clamps to 0..255, repacks RGBA5551.
// Depends on pfi_pkg.
module pfi_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         steps_i,
  input  pfi_pkg::pfi_item_t item_i,
  input  logic               valid_i,
  output logic               done_o,
  output logic [15:0]        faded_color_o
);
  import pfi_pkg::*;

  logic [7:0]  chan [NumChan];
  logic [15:0] color_d, color_q;
  logic        done_q;

  always_comb begin
    logic [15:0] q;
    logic [16:0] sum;
    for (int c = 0; c < NumChan; c++) begin
      q   = item_i.lane[c].dvd;
      sum = {1'b0, q} + {9'd0, item_i.lane[c].orig};
      if (steps_i == 8'd0) begin
        chan[c] = item_i.lane[c].orig;
      end else if (item_i.lane[c].neg) begin
        chan[c] = (q > {8'd0, item_i.lane[c].orig}) ? 8'd0 : (item_i.lane[c].orig - q[7:0]);
      end else begin
        chan[c] = (sum > 17'd255) ? 8'd255 : sum[7:0];
      end
    end
    color_d = item_i.pass ? item_i.cur
                          : {chan[2][7:3], chan[1][7:3], chan[0][7:3], item_i.alpha};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      color_q <= color_d;
    end
  end

  assign done_o        = done_q;
  assign faded_color_o = color_q;

endmodule

[design/palette_fade_interpolator_unit.sv]
// Top level of the palette fade interpolator: config registers, front stage,
// divider cell chain and back stage. Depends on pfi_pkg, pfi_front, pfi_cell, pfi_back.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+---------------------------------------
//  item     | in        | start_i & !busy_o     | entry_index_i, step_index_i,
//           |           |                       | current_color_i, target_color_i
//  result   | out       | done_o (one cycle)    | faded_color_o
//  config   | in        | cfg_we_i              | cfg_idx_i, cfg_wdata_i
//
// One transaction may enter every cycle; busy_o is always low.
// Each result passes through the front stage (unpack and 8x8 multiply), then
// 16 divider cells of one quotient bit each, then the back stage.
// Reset clears the valid chain and loads the register defaults (step count 30,
// range 0..255); results cannot be stalled, done_o strobes for one cycle.
// Registers may only change while no transaction is in flight.
module palette_fade_interpolator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [7:0]  entry_index_i,
  input  logic [7:0]  step_index_i,
  input  logic [15:0] current_color_i,
  input  logic [15:0] target_color_i,
  output logic        done_o,
  output logic [15:0] faded_color_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i
);
  import pfi_pkg::*;

  pfi_cfg_t  cfg_q;
  pfi_item_t stg_item [QBits+1];
  logic      stg_vld  [QBits+1];
  logic      accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // configuration registers, plain write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode      <= 1'b0;
      cfg_q.tgt_red   <= '0;
      cfg_q.tgt_green <= '0;
      cfg_q.tgt_blue  <= '0;
      cfg_q.steps     <= 8'd30;
      cfg_q.rng_start <= 8'd0;
      cfg_q.rng_end   <= 8'd255;
    end else if (cfg_we_i) begin
      case (pfi_reg_e'(cfg_idx_i))
        REG_FADE_MODE:    cfg_q.mode      <= cfg_wdata_i[0];
        REG_TARGET_RED:   cfg_q.tgt_red   <= cfg_wdata_i[5:0];
        REG_TARGET_GREEN: cfg_q.tgt_green <= cfg_wdata_i[5:0];
        REG_TARGET_BLUE:  cfg_q.tgt_blue  <= cfg_wdata_i[5:0];
        REG_STEP_COUNT:   cfg_q.steps     <= cfg_wdata_i;
        REG_RANGE_START:  cfg_q.rng_start <= cfg_wdata_i;
        REG_RANGE_END:    cfg_q.rng_end   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  pfi_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .entry_index_i   (entry_index_i),
    .step_index_i    (step_index_i),
    .current_color_i (current_color_i),
    .target_color_i  (target_color_i),
    .cfg_i           (cfg_q),
    .item_o          (stg_item[0]),
    .valid_o         (stg_vld[0])
  );

  // divider chain, MSB quotient bit first; user holds step count while busy, unchecked
  for (genvar k = 0; k < QBits; k++) begin : g_cell
    pfi_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .divisor_i (cfg_q.steps),
      .item_i    (stg_item[k]),
      .valid_i   (stg_vld[k]),
      .item_o    (stg_item[k+1]),
      .valid_o   (stg_vld[k+1])
    );
  end

  pfi_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .steps_i       (cfg_q.steps),
    .item_i        (stg_item[QBits]),
    .valid_i       (stg_vld[QBits]),
    .done_o        (done_o),
    .faded_color_o (faded_color_o)
  );

endmodule

[design/pfi_checker.sv]
// Port-level checker for the palette fade interpolator, bound to the top level.
// Depends on pfi_pkg.
module pfi_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o
);
  import pfi_pkg::*;

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy_o raised");

  a_start_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##Latency done_o)
    else $error("transaction result missing");

  a_done_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, Latency))
    else $error("result without transaction");

endmodule

bind palette_fade_interpolator_unit pfi_checker u_pfi_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o)
);

[tb/tb_palette_fade_interpolator_unit.sv]
`timescale 1ns / 1ps
// Self-checking testbench for palette_fade_interpolator_unit: directed and random fades,
// scored against an in-bench fade predictor. Depends on pfi_pkg and the RTL top only.
module tb_palette_fade_interpolator_unit;
  import pfi_pkg::*;

  // generous bound on the length of the whole run
  localparam int unsigned CycleLimit = 200000;
  // register index with no register behind it; writes there must change nothing
  localparam logic [2:0]  RegUnused  = 3'd7;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [7:0]  entry_index_i;
  logic [7:0]  step_index_i;
  logic [15:0] current_color_i;
  logic [15:0] target_color_i;
  logic        done_o;
  logic [15:0] faded_color_o;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [7:0]  cfg_wdata_i;

  palette_fade_interpolator_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .entry_index_i  (entry_index_i),
    .step_index_i   (step_index_i),
    .current_color_i(current_color_i),
    .target_color_i (target_color_i),
    .done_o         (done_o),
    .faded_color_o  (faded_color_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  // Scoreboard: keeps a shadow of the fade registers, predicts the faded entry of
  // every accepted transaction and matches results in order.
  class fade_scoreboard;
    pfi_cfg_t    cfg;
    logic [15:0] faded_q[$];
    int unsigned err_count;

    function new();
      cfg           = '0;
      cfg.steps     = 8'd30;
      cfg.rng_end   = 8'd255;
      err_count     = 0;
    endfunction

    // register writes keep only the low bits of each register
    function void set_reg(logic [2:0] idx, logic [7:0] data);
      case (idx)
        REG_FADE_MODE:    cfg.mode      = data[0];
        REG_TARGET_RED:   cfg.tgt_red   = data[5:0];
        REG_TARGET_GREEN: cfg.tgt_green = data[5:0];
        REG_TARGET_BLUE:  cfg.tgt_blue  = data[5:0];
        REG_STEP_COUNT:   cfg.steps     = data;
        REG_RANGE_START:  cfg.rng_start = data;
        REG_RANGE_END:    cfg.rng_end   = data;
        default: ;
      endcase
    endfunction

    // one channel: orig + (tgt - orig) * step / steps, truncating toward zero,
    // clamped to 0..255; a zero step count leaves the channel alone
    function logic [7:0] move_chan(int orig, int tgt, logic [7:0] step);
      int s;
      int n;
      int v;
      s = int'(step);
      n = int'(cfg.steps);
      v = orig;
      if (n != 0) v = orig + ((tgt - orig) * s) / n;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v[7:0];
    endfunction

    function void note_item(logic [7:0] idx, logic [7:0] step, logic [15:0] cur,
                            logic [15:0] tgt);
      int          tr, tg, tb;
      logic [7:0]  r, g, b;
      logic        a;
      logic [15:0] res;
      if (idx < cfg.rng_start || idx > cfg.rng_end) begin
        // outside the range (or empty range): entry passes bit for bit
        res = cur;
      end else begin
        if (cfg.mode) begin
          tr = int'({tgt[15:11], 3'b000});
          tg = int'({tgt[10:6], 3'b000});
          tb = int'({tgt[5:1], 3'b000});
          a  = 1'b1;
        end else begin
          // 6-bit VGA scale widened to 8 bits
          tr = int'(cfg.tgt_red) * 255 / 63;
          tg = int'(cfg.tgt_green) * 255 / 63;
          tb = int'(cfg.tgt_blue) * 255 / 63;
          a  = cur[0];
        end
        r   = move_chan(int'({cur[15:11], 3'b000}), tr, step);
        g   = move_chan(int'({cur[10:6], 3'b000}), tg, step);
        b   = move_chan(int'({cur[5:1], 3'b000}), tb, step);
        res = {r[7:3], g[7:3], b[7:3], a};
      end
      faded_q.push_back(res);
    endfunction

    function void check_result(logic [15:0] got);
      logic [15:0] want;
      if (faded_q.size() == 0) begin
        $error("faded_color: no transaction pending, actual %h", got);
        err_count++;
      end else begin
        want = faded_q.pop_front();
        if (got !== want) begin
          $error("faded_color mismatch: expected %h, actual %h", want, got);
          err_count++;
        end
      end
    endfunction
  endclass

  fade_scoreboard sb;
  int unsigned    cycle_cnt;
  bit             quiet;  // set during the stretch with no sender gaps

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // input side: note every accepted transaction
  always @(posedge clk_i) begin
    if (rst_ni && start_i && !busy_o)
      sb.note_item(entry_index_i, step_index_i, current_color_i, target_color_i);
  end

  // output side: results strobe for one cycle and cannot be held off
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(faded_color_o);
  end

  // Register write; the shadow copy changes on the edge that performs the write.
  task automatic write_reg(logic [2:0] idx, logic [7:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
    cfg_we_i    <= 1'b0;
  endtask

  // Offer one transaction; start stays high into the next call unless a gap follows.
  task automatic send_item(logic [7:0] idx, logic [7:0] step, logic [15:0] cur,
                           logic [15:0] tgt);
    while (!quiet && $urandom_range(99) < 7) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i         <= 1'b1;
    entry_index_i   <= idx;
    step_index_i    <= step;
    current_color_i <= cur;
    target_color_i  <= tgt;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // Hold the sender off until every pending result has been checked.
  // One edge first, so the last accepted transaction is already noted.
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.faded_q.size() != 0) @(posedge clk_i);
  endtask

  // Mostly well-formed fade frames (step below the step count, entry in range),
  // with a share of out-of-range entries and overshooting steps.
  task automatic send_random_item();
    logic [7:0] idx;
    logic [7:0] step;
    if (sb.cfg.rng_start <= sb.cfg.rng_end && $urandom_range(99) < 80)
      idx = 8'($urandom_range(sb.cfg.rng_end, sb.cfg.rng_start));
    else
      idx = 8'($urandom_range(255));
    if (sb.cfg.steps != 0 && $urandom_range(99) < 85)
      step = 8'($urandom_range(sb.cfg.steps - 8'd1));
    else
      step = 8'($urandom_range(255));
    send_item(idx, step, 16'($urandom), 16'($urandom));
  endtask

  function automatic logic [5:0] pick_vga();
    int unsigned k;
    k = $urandom_range(9);
    if (k == 0) return 6'd0;
    if (k == 1) return 6'd63;
    return 6'($urandom);
  endfunction

  // New random register setting, then a run of fade transactions.
  task automatic random_phase(int unsigned n_items);
    int unsigned k;
    logic [7:0]  st;
    logic [7:0]  a0;
    logic [7:0]  a1;
    k = $urandom_range(9);
    case (k)
      0:       st = 8'd0;
      1:       st = 8'd1;
      2:       st = 8'd255;
      default: st = 8'($urandom_range(254, 2));
    endcase
    a0 = 8'($urandom_range(255));
    a1 = 8'($urandom_range(255));
    k  = $urandom_range(9);
    if (k < 4) begin
      a0 = 8'd0;
      a1 = 8'd255;
    end else if (k == 4) begin
      // empty range: start above end
      if (a0 <= a1) begin
        a0 = 8'd200;
        a1 = 8'd100;
      end
    end else if (a0 > a1) begin
      {a0, a1} = {a1, a0};
    end
    // upper bits above each register's width are random and must be ignored
    write_reg(REG_FADE_MODE,    {7'($urandom), 1'($urandom)});
    write_reg(REG_TARGET_RED,   {2'($urandom), pick_vga()});
    write_reg(REG_TARGET_GREEN, {2'($urandom), pick_vga()});
    write_reg(REG_TARGET_BLUE,  {2'($urandom), pick_vga()});
    write_reg(REG_STEP_COUNT,   st);
    write_reg(REG_RANGE_START,  a0);
    write_reg(REG_RANGE_END,    a1);
    repeat (n_items) send_random_item();
    drain();
  endtask

  initial begin
    sb              = new();
    cycle_cnt       = 0;
    quiet           = 1'b0;
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    entry_index_i   = '0;
    step_index_i    = '0;
    current_color_i = '0;
    target_color_i  = '0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_wdata_i     = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset defaults: fade-out to black, 30 steps, full range
    send_item(8'd0,   8'd0,   16'h0000, 16'hFFFF);
    send_item(8'd255, 8'd29,  16'hFFFF, 16'h0000);
    send_item(8'd128, 8'd30,  16'hFFFE, 16'h0000);  // step == count, lands on target
    send_item(8'd7,   8'd255, 16'hAAAA, 16'h5555);  // overshoot, clamps at 0
    drain();

    // fade-out to white over a narrow window; entries at and beyond the edges
    write_reg(REG_TARGET_RED,   8'hFF);
    write_reg(REG_TARGET_GREEN, 8'h3F);
    write_reg(REG_TARGET_BLUE,  8'hC0 | 8'd63);
    write_reg(REG_STEP_COUNT,   8'd255);
    write_reg(REG_RANGE_START,  8'd10);
    write_reg(REG_RANGE_END,    8'd20);
    send_item(8'd9,  8'd254, 16'h1234, 16'hFFFF);
    send_item(8'd10, 8'd254, 16'h0000, 16'h0000);
    send_item(8'd20, 8'd255, 16'h0001, 16'h0000);
    send_item(8'd21, 8'd100, 16'h8001, 16'h0000);
    drain();
    write_reg(REG_STEP_COUNT, 8'd1);
    send_item(8'd15, 8'd255, 16'h0000, 16'h0000);  // overshoot, clamps at 255
    drain();

    // fade-in with zero step count; empty range first, then full range
    write_reg(REG_FADE_MODE,   8'hFF);
    write_reg(REG_STEP_COUNT,  8'd0);
    write_reg(REG_RANGE_START, 8'd255);
    write_reg(REG_RANGE_END,   8'd0);
    send_item(8'd0,   8'd5, 16'hFFFF, 16'h0000);
    send_item(8'd255, 8'd0, 16'h7BDE, 16'hFFFF);
    drain();
    write_reg(REG_RANGE_START, 8'd0);
    write_reg(REG_RANGE_END,   8'd255);
    send_item(8'd255, 8'd0,   16'h0000, 16'hFFFF);  // repacked, alpha forced to 1
    send_item(8'd0,   8'd255, 16'hFFFE, 16'h0000);
    drain();

    // fade-in, one step; stray write to the unused index must not disturb anything
    write_reg(REG_STEP_COUNT, 8'd1);
    write_reg(RegUnused,      8'hFF);
    send_item(8'd3,   8'd0,   16'hF800, 16'h07C0);
    send_item(8'd4,   8'd1,   16'hF800, 16'h07C0);
    send_item(8'd5,   8'd255, 16'h003E, 16'hFFFF);  // below target, clamps at 255
    send_item(8'd6,   8'd255, 16'hFFFF, 16'h0000);  // above target, clamps at 0
    send_item(8'd200, 8'd128, 16'h5555, 16'hAAAA);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      quiet = (ph == 3);
      random_phase(90);
    end
    quiet = 1'b0;

    drain();
    repeat (Latency + 4) @(posedge clk_i);
    if (sb.err_count == 0 && sb.faded_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      if (sb.faded_q.size() != 0)
        $error("faded_color: %0d results never arrived", sb.faded_q.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
